/* hdl/cc11_pkg.sv */
// Shared types, constants and modulo helpers for the Code 11 check digit validator.
`default_nettype none

package cc11_pkg;

   localparam int MAX_DATA_SYMBOLS = 64;
   localparam int POS_LIMIT        = MAX_DATA_SYMBOLS + 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int OUT_DEPTH  = 2;
   localparam int OPTR_W     = $clog2(OUT_DEPTH);
   localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);

   // Symbol classes decided by the front end.
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_CHECK_C = 2'd1;
   localparam logic [1:0] KIND_LAST    = 2'd2;
   localparam logic [1:0] KIND_SKIP    = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] symbol;
      logic [3:0] weight_c;
      logic [3:0] weight_k;
      logic       len_ok;
      logic       n_ok;
   } cc11_item_type;

   typedef struct packed {
      logic barcode_ok;
      logic c_ok;
      logic k_ok;
   } cc11_result_type;

   // Remainder by 10 of a 7-bit value through a reciprocal multiply.
   function automatic logic [3:0] mod10(input logic [6:0] d);
      logic [14:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      prod = 15'(d) * 15'd205;
      q    = prod[14:11];
      r    = d - 7'({3'b000, q} * 7'd10);
      return r[3:0];
   endfunction

   // Remainder by 9 of a 7-bit value through a reciprocal multiply.
   function automatic logic [3:0] mod9(input logic [6:0] d);
      logic [12:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      prod = 13'(d) * 13'd57;
      q    = prod[12:9];
      r    = d - 7'({3'b000, q} * 7'd9);
      return r[3:0];
   endfunction

   // Remainder by 11; exact for inputs up to 160, which covers every running sum.
   function automatic logic [3:0] mod11(input logic [7:0] x);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  r;
      prod = 16'(x) * 16'd187;
      q    = prod[15:11];
      r    = x - 8'({3'b000, q} * 8'd11);
      return r[3:0];
   endfunction

endpackage

`default_nettype wire

/* hdl/cc11_front.sv */
// Front end: tracks the symbol position and classifies each accepted symbol.
`default_nettype none

module cc11_front import cc11_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          take,
   input  wire logic [3:0]    symbol_value,
   input  wire logic [6:0]    data_length,
   input  wire logic          last_symbol,
   output cc11_item_type      item
);

   logic [6:0] pos_ff;
   logic [6:0] pos_in;
   logic [6:0] dist_c;
   logic [6:0] dist_k;

   assign dist_k = data_length - pos_ff;
   assign dist_c = dist_k - 7'd1;

   always_comb begin
      item.symbol   = symbol_value;
      item.weight_c = mod10(dist_c) + 4'd1;
      item.weight_k = mod9(dist_k) + 4'd1;
      item.len_ok   = ({1'b0, pos_ff} == ({1'b0, data_length} + 8'd1));
      item.n_ok     = (data_length >= 7'd1) && (data_length <= 7'(MAX_DATA_SYMBOLS));
      if (last_symbol) begin
         item.kind = KIND_LAST;
      end else if (pos_ff < data_length) begin
         item.kind = KIND_DATA;
      end else if (pos_ff == data_length) begin
         item.kind = KIND_CHECK_C;
      end else begin
         item.kind = KIND_SKIP;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         if (last_symbol) begin
            pos_in = 7'd0;
         end else if (pos_ff < 7'(POS_LIMIT)) begin
            pos_in = pos_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 7'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cc11_queue.sv */
// Short queue of classified symbols between the front end and the back end.
`default_nettype none

module cc11_queue import cc11_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire cc11_item_type push_item,
   output logic               full,
   input  wire logic          pop,
   output cc11_item_type      pop_item,
   output logic               empty
);

   cc11_item_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/cc11_back.sv */
// Back end: running C and K sums modulo 11 and a small buffer of verdicts.
`default_nettype none

module cc11_back import cc11_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          item_empty,
   input  wire cc11_item_type item,
   output logic               item_pop,
   output cc11_result_type    result,
   output logic               result_empty,
   input  wire logic          result_pop
);

   logic [3:0]          c_sum_ff;
   logic [3:0]          c_sum_in;
   logic [3:0]          k_sum_ff;
   logic [3:0]          k_sum_in;
   logic                c_match_ff;
   logic                c_match_in;
   logic                k_ok;
   logic                out_write;
   logic                out_read;
   cc11_result_type     verdict;
   cc11_result_type     out_mem_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]   out_wr_ff;
   logic [OPTR_W-1:0]   out_rd_ff;
   logic [OCNT_W-1:0]   out_count_ff;
   logic [OCNT_W-1:0]   out_count_in;

   // A final symbol is only taken when its verdict has a place to go.
   assign item_pop = !item_empty &&
                     ((item.kind != KIND_LAST) || (out_count_ff != OCNT_W'(OUT_DEPTH)));
   assign out_write = item_pop && (item.kind == KIND_LAST);
   assign out_read  = result_pop && !result_empty;

   assign k_ok               = item.len_ok && (item.symbol == k_sum_ff);
   assign verdict.c_ok       = c_match_ff;
   assign verdict.k_ok       = k_ok;
   assign verdict.barcode_ok = item.len_ok && item.n_ok && c_match_ff && k_ok;

   always_comb begin
      c_sum_in   = c_sum_ff;
      k_sum_in   = k_sum_ff;
      c_match_in = c_match_ff;
      if (item_pop) begin
         unique case (item.kind)
            KIND_DATA: begin
               c_sum_in = mod11(({4'b0000, item.weight_c} * {4'b0000, item.symbol})
                                + {4'b0000, c_sum_ff});
               k_sum_in = mod11(({4'b0000, item.weight_k} * {4'b0000, item.symbol})
                                + {4'b0000, k_sum_ff});
            end
            KIND_CHECK_C: begin
               c_match_in = (item.symbol == c_sum_ff);
               k_sum_in   = mod11({4'b0000, k_sum_ff} + {4'b0000, item.symbol});
            end
            KIND_LAST: begin
               c_sum_in   = 4'd0;
               k_sum_in   = 4'd0;
               c_match_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_count_in = out_count_ff;
      if (out_write && !out_read) begin
         out_count_in = out_count_ff + OCNT_W'(1);
      end else if (out_read && !out_write) begin
         out_count_in = out_count_ff - OCNT_W'(1);
      end
   end

   assign result_empty = (out_count_ff == '0);
   assign result       = out_mem_ff[out_rd_ff];

   always_ff @(posedge clock) begin
      if (out_write) begin
         out_mem_ff[out_wr_ff] <= verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_sum_ff     <= 4'd0;
         k_sum_ff     <= 4'd0;
         c_match_ff   <= 1'b0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         c_sum_ff     <= c_sum_in;
         k_sum_ff     <= k_sum_in;
         c_match_ff   <= c_match_in;
         out_count_ff <= out_count_in;
         if (out_write) begin
            out_wr_ff <= out_wr_ff + OPTR_W'(1);
         end
         if (out_read) begin
            out_rd_ff <= out_rd_ff + OPTR_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

/* hdl/code11_check_digit_validator.sv */
// Code 11 C and K check digit validator, one symbol per cycle in, one verdict per string out.
//
// Symbols of a Code 11 string (data, then the C check, then the K check carrying
// req_last_symbol) are taken one per clock whenever req_full is low; a dash is
// value 10. A front end keeps the symbol position and computes each symbol's C and
// K weights, a four-entry queue holds the classified symbols, and a back end folds
// them into the two sums modulo 11. The verdict for a string is written to a
// two-entry result buffer when its last symbol leaves the queue, and is readable on
// the rsp_ ports from there; the buffer lets input continue while verdicts wait.
// Once both buffered verdicts wait and another last symbol reaches the back end, the
// queue fills and req_full rises until a verdict is popped. The sustained rate is one
// symbol per cycle while req_full stays low.
`default_nettype none

module code11_check_digit_validator import cc11_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [3:0] req_symbol_value,
   input  wire logic [6:0] req_data_length,
   input  wire logic       req_last_symbol,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic            rsp_barcode_ok,
   output logic            rsp_c_digit_ok,
   output logic            rsp_k_digit_ok
);

   cc11_item_type   front_item;
   cc11_item_type   back_item;
   cc11_result_type result;
   logic            queue_full;
   logic            queue_empty;
   logic            queue_pop;
   logic            take;

   assign req_full = queue_full;
   assign take     = req_push && !queue_full;

   cc11_front u_front (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .symbol_value (req_symbol_value),
      .data_length  (req_data_length),
      .last_symbol  (req_last_symbol),
      .item         (front_item)
   );

   cc11_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_item  (back_item),
      .empty     (queue_empty)
   );

   cc11_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_empty   (queue_empty),
      .item         (back_item),
      .item_pop     (queue_pop),
      .result       (result),
      .result_empty (rsp_empty),
      .result_pop   (rsp_pop)
   );

   assign rsp_barcode_ok = result.barcode_ok;
   assign rsp_c_digit_ok = result.c_ok;
   assign rsp_k_digit_ok = result.k_ok;

endmodule

`default_nettype wire

/* hdl/cc11_checker.sv */
// Port-level checks for the Code 11 validator and the bind that attaches them.
`default_nettype none

module cc11_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_full,
   input wire logic rsp_empty,
   input wire logic rsp_pop,
   input wire logic rsp_barcode_ok,
   input wire logic rsp_c_digit_ok,
   input wire logic rsp_k_digit_ok
);

   // No verdict can be pending right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   // The input side is open right after reset.
   a_open_after_reset: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // A passing string implies that both check digits passed.
   a_pass_needs_both: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_barcode_ok) |-> (rsp_c_digit_ok && rsp_k_digit_ok))
      else $error("barcode passed with a failed check digit");

   // A waiting verdict holds until it is transferred.
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
      (!rsp_empty && $stable(rsp_barcode_ok) && $stable(rsp_c_digit_ok)
       && $stable(rsp_k_digit_ok)))
      else $error("waiting verdict changed");

endmodule

bind code11_check_digit_validator cc11_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_barcode_ok (rsp_barcode_ok),
   .rsp_c_digit_ok (rsp_c_digit_ok),
   .rsp_k_digit_ok (rsp_k_digit_ok)
);

`default_nettype wire
